// ----- rtl/ult_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ult_pkg;

    localparam int BUF_BYTES_DEF = 12;

    localparam int          CFG_IDX_W      = 2;
    localparam int          CFG_DATA_W     = 8;
    localparam logic [1:0]  CFG_BIT_PERIOD = 2'd0;
    localparam logic [1:0]  CFG_RX_ENABLE  = 2'd1;

    localparam logic [7:0]  BIT_PERIOD_RST = 8'd104;
    localparam logic [3:0]  TX_FRAME_BITS  = 4'd10;
    localparam logic [3:0]  RX_FRAME_BITS  = 4'd9;
    localparam logic [7:0]  CHAR_LF        = 8'h0A;
    localparam logic [7:0]  CHAR_CR        = 8'h0D;
    localparam logic [9:0]  TX_IDLE_SHIFT  = 10'h3FF;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_SEND = 2'd1,
        REQ_READ = 2'd2,
        REQ_DUMP = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } line_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_READ_OUT = 2'd1,
        ST_DUMP_OUT = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic take;       // input item accepted this cycle
        logic rd_en;      // read the line buffer
        logic load_rd;    // load result register from buffer data
        logic dump_step;  // advance dump position
        logic in_dump;    // a dump is being delivered
    } ult_cmd_t;

    typedef struct packed {
        logic out_free;
        logic dump_last;
    } ult_sts_t;

endpackage

`default_nettype wire

// ----- rtl/uart_line_transceiver_top.sv -----
// Tick and send items give their result in the output register in the cycle after accept;
// a read passes through the registered line buffer read and then the output register.
// Throughput: one tick or send item per cycle while the output register is not stalled; a dump
// gives BUF_BYTES results, one per cycle while not stalled, set by the single buffer read port.
// Reset: aresetn is synchronous, active low; it clears control state and buffer valid bits,
// so unwritten buffer entries read as zero. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module uart_line_transceiver_top #(
    parameter int BUF_BYTES = ult_pkg::BUF_BYTES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ult_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ult_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_req_type,
    input  wire logic                           s_rx_line,
    input  wire logic [7:0]                     s_tx_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_tx_line,
    output logic                                m_busy_res,
    output logic                                m_accepted,
    output logic                                m_rx_event,
    output logic [7:0]                          m_data_byte,
    output logic [3:0]                          m_buf_index,
    output logic                                m_last
);
    import ult_pkg::*;

    ult_cmd_t cmd;
    ult_sts_t sts;

    ult_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_type (s_req_type),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ult_dp #(
        .BUF_BYTES(BUF_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_req_type  (s_req_type),
        .s_rx_line   (s_rx_line),
        .s_tx_byte   (s_tx_byte),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_tx_line   (m_tx_line),
        .m_busy_res  (m_busy_res),
        .m_accepted  (m_accepted),
        .m_rx_event  (m_rx_event),
        .m_data_byte (m_data_byte),
        .m_buf_index (m_buf_index),
        .m_last      (m_last),
        .cmd         (cmd),
        .sts         (sts)
    );

    a_tick_send_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_TICK || s_req_type == REQ_SEND))
        |=> m_valid)
        else $error("tick or send item produced no result");

    a_dump_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_DUMP) |=> !s_ready)
        else $error("input taken while dump pending");

    a_load_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_rd |-> !s_ready)
        else $error("buffer result loaded while accepting input");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_buf_index == 4'(BUF_BYTES - 1)))
        else $error("dump end marker on wrong buffer position");

endmodule

`default_nettype wire

// ----- rtl/ult_linebuf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ult_linebuf #(
    parameter int BUF_BYTES = 12
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(BUF_BYTES)-1:0] wr_addr,
    input  wire logic [7:0]                   wr_data,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(BUF_BYTES)-1:0] rd_addr,
    output logic      [7:0]                   rd_data
);
    import ult_pkg::*;

    logic [7:0]           mem_reg [BUF_BYTES];
    logic [BUF_BYTES-1:0] valid_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_valid_reg;

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule

`default_nettype wire

// ----- rtl/ult_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ult_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic [1:0]       req_type,
    output logic                  s_ready,
    input  wire ult_pkg::ult_sts_t sts,
    output ult_pkg::ult_cmd_t     cmd
);
    import ult_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    req_t        req;

    assign req = req_t'(req_type);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.out_free) begin
                    if (req == REQ_READ) begin
                        state_next = ST_READ_OUT;
                    end else if (req == REQ_DUMP) begin
                        state_next = ST_DUMP_OUT;
                    end
                end
            end
            ST_READ_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_OUT: begin
                if (sts.out_free && sts.dump_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = sts.out_free;
                cmd.take  = s_valid && sts.out_free;
                cmd.rd_en = cmd.take && (req == REQ_READ || req == REQ_DUMP);
            end
            ST_READ_OUT: begin
                cmd.load_rd = sts.out_free;
            end
            ST_DUMP_OUT: begin
                cmd.in_dump   = 1'b1;
                cmd.load_rd   = sts.out_free;
                cmd.dump_step = sts.out_free && !sts.dump_last;
                cmd.rd_en     = cmd.dump_step;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ult_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ult_dp #(
    parameter int BUF_BYTES = 12
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ult_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ult_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic [1:0]                  s_req_type,
    input  wire logic                        s_rx_line,
    input  wire logic [7:0]                  s_tx_byte,
    input  wire logic                        m_ready,
    output logic                             m_valid,
    output logic                             m_tx_line,
    output logic                             m_busy_res,
    output logic                             m_accepted,
    output logic                             m_rx_event,
    output logic [7:0]                       m_data_byte,
    output logic [3:0]                       m_buf_index,
    output logic                             m_last,
    input  wire ult_pkg::ult_cmd_t           cmd,
    output ult_pkg::ult_sts_t                sts
);
    import ult_pkg::*;

    localparam int IDX_W = $clog2(BUF_BYTES);
    localparam logic [IDX_W:0]   WI_MAX    = (IDX_W + 1)'(BUF_BYTES - 2);
    localparam logic [IDX_W-1:0] DUMP_LAST = IDX_W'(BUF_BYTES - 1);

    req_t req;

    // configuration
    logic [7:0] bit_period_reg;
    logic       rx_enable_reg;

    // line engine state
    line_mode_t       mode_reg, mode_next;
    logic [7:0]       tick_count_reg, tick_count_next;
    logic [3:0]       bit_count_reg, bit_count_next;
    logic [9:0]       tx_shift_reg, tx_shift_next;
    logic [7:0]       rx_shift_reg, rx_shift_next;
    logic [IDX_W-1:0] write_index_reg, write_index_next;
    logic             event_flag_reg, event_flag_next;
    logic             pending_nl_reg, pending_nl_next;
    logic             prev_rx_reg, prev_rx_next;
    logic             ev_hold_reg, ev_hold_next;
    logic [IDX_W-1:0] dump_idx_reg, dump_idx_next;

    // result register
    logic       m_valid_reg, m_valid_next;
    logic       m_tx_line_reg, m_busy_res_reg, m_accepted_reg, m_rx_event_reg, m_last_reg;
    logic [7:0] m_data_byte_reg;
    logic [3:0] m_buf_index_reg;

    logic             out_ld;
    logic             o_tx_line, o_busy, o_accepted, o_rx_event, o_last;
    logic [7:0]       o_data;
    logic [3:0]       o_index;
    logic             send_ok;
    logic [7:0]       tick_lim;
    logic [8:0]       tick_inc;
    logic             bit_done;
    logic [3:0]       bit_inc;
    logic [IDX_W:0]   wi_inc;
    logic [IDX_W-1:0] wi_sat;
    logic             buf_wr_en;
    logic [IDX_W-1:0] buf_rd_addr;
    logic [7:0]       buf_rd_data;
    logic [7:0]       frame_byte;

    assign req = req_t'(s_req_type);

    ult_linebuf #(
        .BUF_BYTES(BUF_BYTES)
    ) u_linebuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (buf_wr_en),
        .wr_addr (wi_sat),
        .wr_data (rx_shift_next),
        .rd_en   (cmd.rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    // start bit is sampled after half a period
    always_comb begin
        tick_lim = (mode_reg == MODE_RX && bit_count_reg == 4'd0) ?
                   {1'b0, bit_period_reg[7:1]} : bit_period_reg;
        if (tick_lim == 8'd0) begin
            tick_lim = 8'd1;
        end
    end

    assign tick_inc = {1'b0, tick_count_reg} + 9'd1;
    assign bit_done = tick_inc >= {1'b0, tick_lim};
    assign bit_inc  = bit_count_reg + 4'd1;
    assign wi_inc   = {1'b0, write_index_reg} + (IDX_W + 1)'(1);
    assign wi_sat   = (wi_inc > WI_MAX) ? WI_MAX[IDX_W-1:0] : wi_inc[IDX_W-1:0];
    assign frame_byte = (s_tx_byte == CHAR_LF) ? CHAR_CR : s_tx_byte;

    always_comb begin
        if (cmd.take && req == REQ_DUMP) begin
            buf_rd_addr = '0;
        end else if (cmd.in_dump) begin
            buf_rd_addr = dump_idx_reg + IDX_W'(1);
        end else begin
            buf_rd_addr = write_index_reg;
        end
    end

    always_comb begin
        mode_next        = mode_reg;
        tick_count_next  = tick_count_reg;
        bit_count_next   = bit_count_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        write_index_next = write_index_reg;
        event_flag_next  = event_flag_reg;
        pending_nl_next  = pending_nl_reg;
        prev_rx_next     = prev_rx_reg;
        ev_hold_next     = ev_hold_reg;
        dump_idx_next    = dump_idx_reg;
        send_ok          = 1'b0;
        buf_wr_en        = 1'b0;

        if (cmd.take) begin
            case (req)
                REQ_TICK: begin
                    prev_rx_next = s_rx_line;
                    case (mode_reg)
                        MODE_TX: begin
                            if (bit_done) begin
                                tick_count_next = 8'd0;
                                tx_shift_next   = {1'b1, tx_shift_reg[9:1]};
                                bit_count_next  = bit_inc;
                                if (bit_inc >= TX_FRAME_BITS) begin
                                    bit_count_next = 4'd0;
                                    if (pending_nl_reg) begin
                                        // second frame of a CR LF pair
                                        pending_nl_next = 1'b0;
                                        tx_shift_next   = {CHAR_LF, 2'b01};
                                    end else begin
                                        mode_next     = MODE_IDLE;
                                        tx_shift_next = TX_IDLE_SHIFT;
                                    end
                                end
                            end else begin
                                tick_count_next = tick_inc[7:0];
                            end
                        end
                        MODE_RX: begin
                            if (bit_done) begin
                                tick_count_next = 8'd0;
                                if (bit_count_reg != 4'd0) begin
                                    rx_shift_next = {s_rx_line, rx_shift_reg[7:1]};
                                end
                                bit_count_next = bit_inc;
                                if (bit_inc >= RX_FRAME_BITS) begin
                                    write_index_next = wi_sat;
                                    buf_wr_en        = 1'b1;
                                    event_flag_next  = 1'b1;
                                    mode_next        = MODE_IDLE;
                                    bit_count_next   = 4'd0;
                                end
                            end else begin
                                tick_count_next = tick_inc[7:0];
                            end
                        end
                        default: begin
                            if (rx_enable_reg && prev_rx_reg && !s_rx_line) begin
                                mode_next       = MODE_RX;
                                tick_count_next = 8'd0;
                                bit_count_next  = 4'd0;
                                rx_shift_next   = 8'd0;
                            end
                        end
                    endcase
                end
                REQ_SEND: begin
                    if (mode_reg == MODE_IDLE && !pending_nl_reg) begin
                        send_ok         = 1'b1;
                        pending_nl_next = (s_tx_byte == CHAR_LF);
                        tx_shift_next   = {frame_byte, 2'b01};
                        tick_count_next = 8'd0;
                        bit_count_next  = 4'd0;
                        mode_next       = MODE_TX;
                    end
                end
                REQ_READ: begin
                    ev_hold_next    = event_flag_reg;
                    event_flag_next = 1'b0;
                end
                REQ_DUMP: begin
                    ev_hold_next     = event_flag_reg;
                    write_index_next = '0;
                    dump_idx_next    = '0;
                end
                default: begin
                    ev_hold_next = ev_hold_reg;
                end
            endcase
        end

        if (cmd.dump_step) begin
            dump_idx_next = dump_idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        out_ld = cmd.load_rd || (cmd.take && (req == REQ_TICK || req == REQ_SEND));
        if (cmd.load_rd) begin
            o_tx_line  = tx_shift_reg[0];
            o_busy     = (mode_reg != MODE_IDLE);
            o_accepted = 1'b0;
            o_rx_event = ev_hold_reg;
            o_data     = buf_rd_data;
            o_index    = cmd.in_dump ? 4'(dump_idx_reg) : 4'(write_index_reg);
            o_last     = cmd.in_dump && (dump_idx_reg == DUMP_LAST);
        end else begin
            o_tx_line  = tx_shift_next[0];
            o_busy     = (mode_next != MODE_IDLE);
            o_accepted = send_ok;
            o_rx_event = event_flag_next;
            o_data     = 8'h00;
            o_index    = 4'd0;
            o_last     = 1'b0;
        end
        if (out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg  <= BIT_PERIOD_RST;
            rx_enable_reg   <= 1'b0;
            mode_reg        <= MODE_IDLE;
            tick_count_reg  <= 8'd0;
            bit_count_reg   <= 4'd0;
            tx_shift_reg    <= TX_IDLE_SHIFT;
            rx_shift_reg    <= 8'd0;
            write_index_reg <= '0;
            event_flag_reg  <= 1'b0;
            pending_nl_reg  <= 1'b0;
            prev_rx_reg     <= 1'b1;
            ev_hold_reg     <= 1'b0;
            dump_idx_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == CFG_BIT_PERIOD) begin
                bit_period_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == CFG_RX_ENABLE) begin
                rx_enable_reg <= cfg_wr_data[0];
            end
            mode_reg        <= mode_next;
            tick_count_reg  <= tick_count_next;
            bit_count_reg   <= bit_count_next;
            tx_shift_reg    <= tx_shift_next;
            rx_shift_reg    <= rx_shift_next;
            write_index_reg <= write_index_next;
            event_flag_reg  <= event_flag_next;
            pending_nl_reg  <= pending_nl_next;
            prev_rx_reg     <= prev_rx_next;
            ev_hold_reg     <= ev_hold_next;
            dump_idx_reg    <= dump_idx_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            m_tx_line_reg   <= o_tx_line;
            m_busy_res_reg  <= o_busy;
            m_accepted_reg  <= o_accepted;
            m_rx_event_reg  <= o_rx_event;
            m_data_byte_reg <= o_data;
            m_buf_index_reg <= o_index;
            m_last_reg      <= o_last;
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.dump_last = (dump_idx_reg == DUMP_LAST);

    assign m_valid     = m_valid_reg;
    assign m_tx_line   = m_tx_line_reg;
    assign m_busy_res  = m_busy_res_reg;
    assign m_accepted  = m_accepted_reg;
    assign m_rx_event  = m_rx_event_reg;
    assign m_data_byte = m_data_byte_reg;
    assign m_buf_index = m_buf_index_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

// ----- bench/uart_line_transceiver_checker.sv -----
`timescale 1ns / 1ps

module uart_line_transceiver_checker #(
    parameter int BUF_BYTES = ult_pkg::BUF_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ult_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ult_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic                           s_rx_line,
    input  logic [7:0]                     s_tx_byte,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_tx_line,
    input  logic                           m_busy_res,
    input  logic                           m_accepted,
    input  logic                           m_rx_event,
    input  logic [7:0]                     m_data_byte,
    input  logic [3:0]                     m_buf_index,
    input  logic                           m_last,
    output int                             mismatch_count,
    output int                             outstanding
);

    import ult_pkg::*;

    typedef struct packed {
        logic       tx_line;
        logic       busy;
        logic       accepted;
        logic       rx_event;
        logic [7:0] data_byte;
        logic [3:0] buf_index;
        logic       last;
    } line_status_t;

    line_status_t line_status_due[$];

    // shadow of the transceiver state
    line_mode_t  lmode;
    logic [7:0]  tick_cnt;
    logic [3:0]  bit_cnt;
    logic [9:0]  tx_frame;
    logic [7:0]  rx_byte;
    logic [7:0]  rx_store [BUF_BYTES];
    int          store_idx;
    logic        event_flag;
    logic        lf_pending;
    logic        last_rx_line;
    logic [7:0]  cfg_period;
    logic        cfg_rx_en;

    task automatic clear_line_state();
        int k;
        lmode        = MODE_IDLE;
        tick_cnt     = '0;
        bit_cnt      = '0;
        tx_frame     = TX_IDLE_SHIFT;
        rx_byte      = '0;
        for (k = 0; k < BUF_BYTES; k++) rx_store[k] = '0;
        store_idx    = 0;
        event_flag   = 1'b0;
        lf_pending   = 1'b0;
        last_rx_line = 1'b1;
        cfg_period   = BIT_PERIOD_RST;
        cfg_rx_en    = 1'b0;
    endtask

    // frame shifts out: idle-high bit, start bit, then data LSB first
    task automatic load_tx_frame(input logic [7:0] data);
        tx_frame = {data, 2'b01};
        tick_cnt = '0;
        bit_cnt  = '0;
        lmode    = MODE_TX;
    endtask

    task automatic advance_bit_clock(input logic line);
        logic [8:0] span;
        logic [8:0] next_cnt;
        next_cnt = tick_cnt + 9'd1;
        case (lmode)
            MODE_TX: begin
                span = (cfg_period == 0) ? 9'd1 : {1'b0, cfg_period};
                if (next_cnt >= span) begin
                    tick_cnt = '0;
                    tx_frame = {1'b1, tx_frame[9:1]};
                    bit_cnt++;
                    if (bit_cnt >= TX_FRAME_BITS) begin
                        if (lf_pending) begin
                            lf_pending = 1'b0;
                            load_tx_frame(CHAR_LF);
                        end else begin
                            lmode    = MODE_IDLE;
                            bit_cnt  = '0;
                            tx_frame = TX_IDLE_SHIFT;
                        end
                    end
                end else begin
                    tick_cnt = next_cnt[7:0];
                end
            end
            MODE_RX: begin
                // start bit is sampled after half a period
                span = (bit_cnt == 0) ? ({1'b0, cfg_period} >> 1) : {1'b0, cfg_period};
                if (span == 0) span = 9'd1;
                if (next_cnt >= span) begin
                    tick_cnt = '0;
                    if (bit_cnt != 0) rx_byte = {line, rx_byte[7:1]};
                    bit_cnt++;
                    if (bit_cnt >= RX_FRAME_BITS) begin
                        if (store_idx < BUF_BYTES - 2) store_idx++;
                        rx_store[store_idx] = rx_byte;
                        event_flag = 1'b1;
                        lmode      = MODE_IDLE;
                        bit_cnt    = '0;
                    end
                end else begin
                    tick_cnt = next_cnt[7:0];
                end
            end
            default: begin
                if (cfg_rx_en && last_rx_line && !line) begin
                    lmode    = MODE_RX;
                    tick_cnt = '0;
                    bit_cnt  = '0;
                    rx_byte  = '0;
                end
            end
        endcase
        last_rx_line = line;
    endtask

    function automatic line_status_t line_now();
        line_status_t r;
        r         = '0;
        r.tx_line = tx_frame[0];
        r.busy    = (lmode != MODE_IDLE);
        return r;
    endfunction

    task automatic apply_uart_item(input logic [1:0] req, input logic line,
                                   input logic [7:0] tx_data);
        line_status_t r;
        logic         ev_before;
        logic         took;
        int           k;
        ev_before = event_flag;
        took      = 1'b0;
        case (req_t'(req))
            REQ_TICK: begin
                advance_bit_clock(line);
                r          = line_now();
                r.rx_event = event_flag;
                line_status_due.push_back(r);
            end
            REQ_SEND: begin
                if (lmode == MODE_IDLE && !lf_pending) begin
                    if (tx_data == CHAR_LF) begin
                        lf_pending = 1'b1;
                        load_tx_frame(CHAR_CR);
                    end else begin
                        load_tx_frame(tx_data);
                    end
                    took = 1'b1;
                end
                r          = line_now();
                r.accepted = took;
                r.rx_event = ev_before;
                line_status_due.push_back(r);
            end
            REQ_READ: begin
                event_flag  = 1'b0;
                r           = line_now();
                r.rx_event  = ev_before;
                r.data_byte = rx_store[store_idx];
                r.buf_index = store_idx[3:0];
                line_status_due.push_back(r);
            end
            default: begin
                for (k = 0; k < BUF_BYTES; k++) begin
                    r           = line_now();
                    r.rx_event  = ev_before;
                    r.data_byte = rx_store[k];
                    r.buf_index = k[3:0];
                    r.last      = (k == BUF_BYTES - 1);
                    line_status_due.push_back(r);
                end
                store_idx = 0;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        line_status_t got;
        line_status_t want;
        if (!aresetn) begin
            clear_line_state();
            line_status_due.delete();
            mismatch_count = 0;
        end else begin
            // results never share a cycle with the item that caused them
            if (m_valid && m_ready) begin
                got = {m_tx_line, m_busy_res, m_accepted, m_rx_event,
                       m_data_byte, m_buf_index, m_last};
                if (line_status_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing due: tx=%b busy=%b acc=%b ev=%b data=%h idx=%0d last=%b",
                                 $time, got.tx_line, got.busy, got.accepted, got.rx_event,
                                 got.data_byte, got.buf_index, got.last);
                end else begin
                    want = line_status_due.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch exp tx=%b busy=%b acc=%b ev=%b data=%h idx=%0d last=%b | got tx=%b busy=%b acc=%b ev=%b data=%h idx=%0d last=%b",
                                     $time, want.tx_line, want.busy, want.accepted,
                                     want.rx_event, want.data_byte, want.buf_index, want.last,
                                     got.tx_line, got.busy, got.accepted, got.rx_event,
                                     got.data_byte, got.buf_index, got.last);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BIT_PERIOD: cfg_period = cfg_wr_data;
                    CFG_RX_ENABLE:  cfg_rx_en  = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) apply_uart_item(s_req_type, s_rx_line, s_tx_byte);
        end
        outstanding <= line_status_due.size();
    end

endmodule

// ----- bench/uart_line_transceiver_top_tb.sv -----
`timescale 1ns / 1ps

module uart_line_transceiver_top_tb;

    import ult_pkg::*;

    localparam int          RUN_LIMIT       = 1_000_000;
    localparam int          HOLD_CYCLES     = 300;
    localparam logic [1:0]  CFG_UNMAPPED_LO = 2'd2;
    localparam logic [1:0]  CFG_UNMAPPED_HI = 2'd3;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type  = REQ_TICK;
    logic                  s_rx_line   = 1'b1;
    logic [7:0]            s_tx_byte   = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_tx_line;
    logic                  m_busy_res;
    logic                  m_accepted;
    logic                  m_rx_event;
    logic [7:0]            m_data_byte;
    logic [3:0]            m_buf_index;
    logic                  m_last;

    int          mismatch_count;
    int          outstanding;
    int          cycle_count    = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          extra_req_pct  = 0;
    int          hold_left      = 0;
    logic        hold_trigger   = 1'b0;
    logic [7:0]  period_now     = BIT_PERIOD_RST;

    uart_line_transceiver_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_rx_line   (s_rx_line),
        .s_tx_byte   (s_tx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tx_line   (m_tx_line),
        .m_busy_res  (m_busy_res),
        .m_accepted  (m_accepted),
        .m_rx_event  (m_rx_event),
        .m_data_byte (m_data_byte),
        .m_buf_index (m_buf_index),
        .m_last      (m_last)
    );

    uart_line_transceiver_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_rx_line      (s_rx_line),
        .s_tx_byte      (s_tx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tx_line      (m_tx_line),
        .m_busy_res     (m_busy_res),
        .m_accepted     (m_accepted),
        .m_rx_event     (m_rx_event),
        .m_data_byte    (m_data_byte),
        .m_buf_index    (m_buf_index),
        .m_last         (m_last),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[uart_line_transceiver_top] ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_trigger) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // returns at the edge where the item is accepted
    task automatic drive_item(input req_t req, input logic line, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_rx_line  <= line;
        s_tx_byte  <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BIT_PERIOD) period_now = value;
        @(posedge aclk);
    endtask

    // a tick, now and then preceded by a stray request
    task automatic tick_line(input logic line);
        if ($urandom_range(99) < extra_req_pct)
            drive_item(req_t'($urandom_range(1, 3)), 1'($urandom_range(1)),
                       8'($urandom_range(255)));
        drive_item(REQ_TICK, line, 8'($urandom_range(255)));
    endtask

    task automatic tick_run(input int n, input logic line);
        repeat (n) tick_line(line);
    endtask

    function automatic int bit_ticks();
        return (period_now == 0) ? 1 : period_now;
    endfunction

    task automatic send_frame(input logic [7:0] data);
        drive_item(REQ_SEND, 1'($urandom_range(1)), data);
        tick_run(((data == CHAR_LF) ? 20 : 10) * bit_ticks() + 2, 1'b1);
    endtask

    // drives serial bits first_bit..end_bit-1 of an 8N1 frame on rx
    task automatic rx_frame_part(input logic [7:0] data, input int first_bit,
                                 input int end_bit, input int lead);
        logic [9:0] frame_bits;
        int         b;
        frame_bits = {1'b1, data, 1'b0};
        tick_run(lead, 1'b1);
        for (b = first_bit; b < end_bit; b++) tick_run(bit_ticks(), frame_bits[b]);
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            rx_frame_part(8'($urandom_range(255)), 0, 10, $urandom_range(1, 3));
        end else if (pick < 60) begin
            send_frame(($urandom_range(5) == 0) ? CHAR_LF : 8'($urandom_range(255)));
        end else if (pick < 68) begin
            // start edge arrives while transmitting
            drive_item(REQ_SEND, 1'b1, 8'($urandom_range(255)));
            rx_frame_part(8'($urandom_range(255)), 0, 10, 0);
        end else if (pick < 80) begin
            drive_item(REQ_READ, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end else if (pick < 84) begin
            drive_item(REQ_DUMP, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end else if (pick < 93) begin
            repeat ($urandom_range(1, 2 * bit_ticks())) tick_line(1'($urandom_range(1)));
        end else begin
            drive_item(REQ_SEND, 1'b1, 8'($urandom_range(255)));
            drive_item(REQ_SEND, 1'b1, 8'($urandom_range(255)));
            tick_run(10 * bit_ticks() + 2, 1'b1);
        end
    endtask

    initial begin
        int phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset state: empty buffer, receive off, long bit period
        drive_item(REQ_READ, 1'b1, 8'h00);
        drive_item(REQ_DUMP, 1'b0, 8'hFF);
        drive_item(REQ_TICK, 1'b0, 8'h00);
        drive_item(REQ_TICK, 1'b1, 8'h00);
        settle();
        write_reg(CFG_BIT_PERIOD, 8'd1);
        write_reg(CFG_RX_ENABLE, 8'd1);

        drive_item(REQ_SEND, 1'b1, 8'h00);
        drive_item(REQ_SEND, 1'b1, 8'hFF);          // rejected, busy
        tick_run(10, 1'b1);
        drive_item(REQ_SEND, 1'b0, CHAR_LF);        // goes out as CR then LF
        tick_run(10, 1'b1);
        drive_item(REQ_SEND, 1'b1, 8'h55);          // rejected while the LF frame still goes out
        tick_run(10, 1'b1);

        rx_frame_part(8'hA5, 0, 10, 1);
        drive_item(REQ_READ, 1'b0, 8'h00);

        // low line during transmit, held low after: no reception
        drive_item(REQ_SEND, 1'b1, 8'h81);
        tick_run(11, 1'b0);
        tick_run(1, 1'b1);

        // receive enable dropped mid-frame
        rx_frame_part(8'hC3, 0, 5, 1);
        settle();
        write_reg(CFG_RX_ENABLE, 8'd0);
        rx_frame_part(8'hC3, 5, 10, 0);
        drive_item(REQ_READ, 1'b0, 8'h00);
        // falling edge with receive off
        tick_run(1, 1'b1);
        tick_run(2, 1'b0);
        settle();

        write_reg(CFG_BIT_PERIOD, 8'd0);
        write_reg(CFG_RX_ENABLE, 8'd1);
        rx_frame_part(8'hF0, 0, 10, 1);
        drive_item(REQ_READ, 1'b1, 8'h00);
        settle();
        write_reg(CFG_UNMAPPED_LO, 8'hFF);
        write_reg(CFG_UNMAPPED_HI, 8'h00);
        drive_item(REQ_SEND, 1'b1, 8'hA0);
        tick_run(3, 1'b1);

        extra_req_pct = 3;
        for (phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct = 69; sink_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct <= 69; end
                default: begin src_idle_pct = 34; sink_stall_pct <= 34; end
            endcase
            write_reg(CFG_BIT_PERIOD, (phase == 1) ? 8'd1 : 8'($urandom_range(1, 2)));
            write_reg(CFG_RX_ENABLE, 8'd1);
            if (phase == 0) begin
                // result side holds off while items keep coming
                hold_trigger <= 1'b1;
                @(posedge aclk);
                hold_trigger <= 1'b0;
                tick_run(4, 1'b1);
            end
            random_sequence();
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("[uart_line_transceiver_top] OK");
        end else begin
            $display("[uart_line_transceiver_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ult_pkg.sv
rtl/ult_linebuf.sv
rtl/ult_ctrl.sv
rtl/ult_dp.sv
rtl/uart_line_transceiver_top.sv
bench/uart_line_transceiver_checker.sv
bench/uart_line_transceiver_top_tb.sv
